[src/hsh_pkg.sv]
// Shared types, constants and the SipRound function for the HalfSipHash-2-4 block.
// No dependencies; used by hsh_ctrl, hsh_dp and the top level.
package hsh_pkg;

    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int PART_W     = 24;
    localparam int PHASE_W    = 2;
    localparam int LEN_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int RCNT_W     = 2;

    localparam logic [WORD_W-1:0] SIP_C2         = 32'h6c796765;
    localparam logic [WORD_W-1:0] SIP_C3         = 32'h74656462;
    localparam logic [WORD_W-1:0] SIP_FINAL_XOR  = 32'h000000ff;
    localparam logic [WORD_W-1:0] KEY_LOW_RESET  = 32'hded6cbc7;
    localparam logic [WORD_W-1:0] KEY_HIGH_RESET = 32'h81875fe8;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_FULL = 2'd3;
    localparam logic [RCNT_W-1:0]  ABS_LAST   = 2'd1;
    localparam logic [RCNT_W-1:0]  FIN_LAST   = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } hsh_words_t;

    typedef struct packed {
        logic accept;
        logic round;
        logic pre_xor;
        logic post_xor;
        logic fin_xor;
        logic load_final;
        logic emit;
    } hsh_cmd_t;

    typedef struct packed {
        logic full_word;
        logic out_free;
    } hsh_sts_t;

    function automatic hsh_words_t sip_round(input hsh_words_t w);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        hsh_words_t r;
        a = w.v0;
        b = w.v1;
        c = w.v2;
        d = w.v3;
        a = a + b;
        b = {b[26:0], b[31:27]};
        b = b ^ a;
        a = {a[15:0], a[31:16]};
        c = c + d;
        d = {d[23:0], d[31:24]};
        d = d ^ c;
        a = a + d;
        d = {d[24:0], d[31:25]};
        d = d ^ a;
        c = c + b;
        b = {b[18:0], b[31:19]};
        b = b ^ c;
        c = {c[15:0], c[31:16]};
        r.v0 = a;
        r.v1 = b;
        r.v2 = c;
        r.v3 = d;
        return r;
    endfunction

endpackage

[src/hsh_dp.sv]
// Datapath: key registers, sip words, byte packing, one SipRound per cycle, result register.
// Depends on hsh_pkg; driven by commands from hsh_ctrl.
module hsh_dp
    import hsh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hsh_cmd_t               cmd,
    output hsh_sts_t               sts,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   byte_present,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [WORD_W-1:0]      hash_value
);

    logic [WORD_W-1:0]  key_low_reg, key_high_reg;
    hsh_words_t         v_reg, v_next;
    logic [WORD_W-1:0]  m_reg, m_next;
    logic [PART_W-1:0]  part_reg, part_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               in_msg_reg, in_msg_next;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  hash_reg;

    logic [PART_W-1:0]  part_eff;
    logic [PHASE_W-1:0] phase_eff;
    logic [LEN_W-1:0]   len_eff;
    logic [PART_W-1:0]  part_acc;
    logic [PHASE_W-1:0] phase_acc;
    logic [LEN_W-1:0]   len_acc;
    logic               full_word;
    hsh_words_t         round_in, round_out;

    assign part_eff  = in_msg_reg ? part_reg  : '0;
    assign phase_eff = in_msg_reg ? phase_reg : '0;
    assign len_eff   = in_msg_reg ? len_reg   : '0;
    assign full_word = byte_present && (phase_eff == PHASE_FULL);

    always_comb
    begin
        part_acc  = part_eff;
        phase_acc = phase_eff;
        len_acc   = len_eff;
        if (byte_present)
        begin
            len_acc = len_eff + LEN_W'(1);
            if (full_word)
            begin
                part_acc  = '0;
                phase_acc = '0;
            end
            else
            begin
                part_acc  = part_eff | (PART_W'(data_byte) << (BYTE_W * phase_eff));
                phase_acc = phase_eff + PHASE_W'(1);
            end
        end
    end

    always_comb
    begin
        round_in = v_reg;
        if (cmd.pre_xor)
            round_in.v3 = v_reg.v3 ^ m_reg;
        if (cmd.fin_xor)
            round_in.v2 = v_reg.v2 ^ SIP_FINAL_XOR;
        round_out = sip_round(round_in);
        if (cmd.post_xor)
            round_out.v0 = round_out.v0 ^ m_reg;
    end

    always_comb
    begin
        v_next      = v_reg;
        m_next      = m_reg;
        part_next   = part_reg;
        phase_next  = phase_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        if (cmd.accept)
        begin
            if (!in_msg_reg)
            begin
                v_next.v0 = key_low_reg;
                v_next.v1 = key_high_reg;
                v_next.v2 = key_low_reg ^ SIP_C2;
                v_next.v3 = key_high_reg ^ SIP_C3;
            end
            part_next   = part_acc;
            phase_next  = phase_acc;
            len_next    = len_acc;
            in_msg_next = 1'b1;
            m_next      = full_word ? {data_byte, part_eff} : {len_acc, part_acc};
        end
        if (cmd.round)
            v_next = round_out;
        if (cmd.load_final)
            m_next = {len_reg, part_reg};
        if (cmd.emit)
        begin
            part_next   = '0;
            phase_next  = '0;
            len_next    = '0;
            in_msg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= KEY_LOW_RESET;
            key_high_reg  <= KEY_HIGH_RESET;
            v_reg         <= '0;
            part_reg      <= '0;
            phase_reg     <= '0;
            len_reg       <= '0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_KEY_LOW))
                key_low_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_KEY_HIGH))
                key_high_reg <= cfg_data;
            v_reg      <= v_next;
            part_reg   <= part_next;
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            in_msg_reg <= in_msg_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        if (cmd.emit)
            hash_reg <= v_reg.v1 ^ v_reg.v3;
    end

    assign sts.full_word = full_word;
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign hash_value    = hash_reg;

endmodule

[src/hsh_ctrl.sv]
// Controller: sequences request intake, word compression, finalization and result hand-off.
// Depends on hsh_pkg; drives hsh_dp through hsh_cmd_t and reads hsh_sts_t.
module hsh_ctrl
    import hsh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     byte_present,
    input  logic     last,
    output logic     in_stall,
    input  hsh_sts_t sts,
    output hsh_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ABS  = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [RCNT_W-1:0]  cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic               final_reg, final_next;
    logic               active;

    assign active   = in_valid && (byte_present || last);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        final_next = final_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (active)
                begin
                    cmd.accept = 1'b1;
                    last_next  = last;
                    final_next = !sts.full_word;
                    cnt_next   = '0;
                    if (sts.full_word || last)
                        state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                cmd.round = 1'b1;
                if (cnt_reg == ABS_LAST)
                begin
                    cmd.post_xor = 1'b1;
                    cnt_next     = '0;
                    if (final_reg)
                        state_next = S_FIN;
                    else if (last_reg)
                    begin
                        cmd.load_final = 1'b1;
                        final_next     = 1'b1;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    cmd.pre_xor = 1'b1;
                    cnt_next    = cnt_reg + RCNT_W'(1);
                end
            end
            S_FIN:
            begin
                cmd.round   = 1'b1;
                cmd.fin_xor = (cnt_reg == '0);
                cnt_next    = cnt_reg + RCNT_W'(1);
                if (cnt_reg == FIN_LAST)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            final_reg <= final_next;
        end
    end

endmodule

[src/halfsiphash_2_4_byte_stream.sv]
// Top level of the keyed HalfSipHash-2-4 byte-stream hasher.
// Depends on hsh_pkg, hsh_ctrl and hsh_dp.
//
// channel  handshake             payload
// -------  --------------------  ------------------------------------
// in       in_valid / in_stall   data_byte, byte_present, last
// out      out_valid / out_stall hash_value
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (0 key_low, 1 key_high)
//
// A byte that does not complete a word is accepted without an input stall;
// a completed word is compressed through the single round unit, one
// SipRound per cycle. A last request adds the final word (after any word
// its byte completes), 4 finalization rounds and a result register load.
// Reset clears the message state and returns the keys to their defaults.
// The result waits in its register under out_stall while the next request
// is taken; a further result holds until that register is free.
module halfsiphash_2_4_byte_stream
    import hsh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   byte_present,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WORD_W-1:0]      hash_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    hsh_cmd_t cmd;
    hsh_sts_t sts;

    assign cfg_ready = 1'b1;

    hsh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .byte_present (byte_present),
        .last         (last),
        .in_stall     (in_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    hsh_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .hash_value   (hash_value)
    );

endmodule

[bench/halfsiphash_2_4_byte_stream_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the HalfSipHash-2-4 byte-stream hasher: a queue-fed driver,
// an output monitor and a cycle-free hash predictor, with key changes between phases.
// Depends on hsh_pkg and halfsiphash_2_4_byte_stream.
module halfsiphash_2_4_byte_stream_tb;
    import hsh_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              last;
        logic [2:0]        gap;
        logic              drain;
    } hash_req_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      data_byte;
    logic                   byte_present;
    logic                   last;
    logic                   out_valid;
    logic                   out_stall;
    logic [WORD_W-1:0]      hash_value;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;

    hash_req_t         pending_reqs[$];
    hash_req_t         next_req;
    logic [WORD_W-1:0] expected_hashes[$];
    logic [WORD_W-1:0] want_hash;

    logic [WORD_W-1:0] key_lo_m;
    logic [WORD_W-1:0] key_hi_m;
    logic [WORD_W-1:0] sip_v[4];
    logic [PART_W-1:0] part_word;
    logic [PHASE_W-1:0] part_bytes;
    logic [LEN_W-1:0]  msg_len;
    logic              msg_open;

    int  fail_count = 0;
    int  item_count = 0;
    int  gap_max = 6;
    int  stall_max = 6;
    int  stall_left = 0;
    bit  in_took = 1'b0;

    halfsiphash_2_4_byte_stream u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    task automatic sip_mix();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        a = sip_v[0];
        b = sip_v[1];
        c = sip_v[2];
        d = sip_v[3];
        a = a + b;
        b = rotl(b, 5) ^ a;
        a = rotl(a, 16);
        c = c + d;
        d = rotl(d, 8) ^ c;
        a = a + d;
        d = rotl(d, 7) ^ a;
        c = c + b;
        b = rotl(b, 13) ^ c;
        c = rotl(c, 16);
        sip_v[0] = a;
        sip_v[1] = b;
        sip_v[2] = c;
        sip_v[3] = d;
    endtask

    task automatic compress_word(input logic [WORD_W-1:0] m);
        sip_v[3] = sip_v[3] ^ m;
        sip_mix();
        sip_mix();
        sip_v[0] = sip_v[0] ^ m;
    endtask

    task automatic hash_step(input logic [BYTE_W-1:0] d, input logic p, input logic l);
        if (p || l)
        begin
            if (!msg_open)
            begin
                sip_v[0]   = key_lo_m;
                sip_v[1]   = key_hi_m;
                sip_v[2]   = key_lo_m ^ SIP_C2;
                sip_v[3]   = key_hi_m ^ SIP_C3;
                part_word  = '0;
                part_bytes = '0;
                msg_len    = '0;
                msg_open   = 1'b1;
            end
            if (p)
            begin
                if (part_bytes == PHASE_FULL)
                begin
                    compress_word({d, part_word});
                    part_word  = '0;
                    part_bytes = '0;
                end
                else
                begin
                    part_word  = part_word | (PART_W'(d) << (8 * part_bytes));
                    part_bytes = part_bytes + 1'b1;
                end
                msg_len = msg_len + 1'b1;
            end
            if (l)
            begin
                compress_word({msg_len, part_word});
                sip_v[2] = sip_v[2] ^ SIP_FINAL_XOR;
                repeat (4) sip_mix();
                expected_hashes.push_back(sip_v[1] ^ sip_v[3]);
                part_word  = '0;
                part_bytes = '0;
                msg_len    = '0;
                msg_open   = 1'b0;
            end
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic push_req(input logic [BYTE_W-1:0] d, input logic p, input logic l,
                            input logic drain);
        hash_req_t r;
        r.data_byte    = d;
        r.byte_present = p;
        r.last         = l;
        r.gap          = (gap_max == 0) ? 3'd0 : 3'($urandom_range(0, gap_max));
        r.drain        = drain;
        pending_reqs.push_back(r);
        if (p || l)
            item_count++;
    endtask

    task automatic queue_message(input int len, input logic drain);
        bit empty_end;
        empty_end = (len == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_req(8'($urandom), 1'b0, 1'b0, 1'b0);
            push_req(8'($urandom), 1'b1, (i == len - 1) && !empty_end, drain && (i == 0));
        end
        if (empty_end)
            push_req(8'($urandom), 1'b0, 1'b1, drain && (len == 0));
    endtask

    task automatic write_key(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_KEY_LOW)
            key_lo_m = val;
        else
            key_hi_m = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || in_valid || expected_hashes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            in_took = 1'b0;
            if (pending_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (pending_reqs[0].drain && expected_hashes.size() != 0)
            begin
                in_valid <= 1'b0;
            end
            else if (pending_reqs[0].gap != 0)
            begin
                pending_reqs[0].gap = pending_reqs[0].gap - 1'b1;
                in_valid <= 1'b0;
            end
            else
            begin
                next_req = pending_reqs.pop_front();
                in_valid     <= 1'b1;
                data_byte    <= next_req.data_byte;
                byte_present <= next_req.byte_present;
                last         <= next_req.last;
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_valid && stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                hash_step(data_byte, byte_present, last);
                in_took = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    note_failure($sformatf("unexpected hash_value %h", hash_value));
                end
                else
                begin
                    want_hash = expected_hashes.pop_front();
                    if (hash_value !== want_hash)
                        note_failure($sformatf("hash_value mismatch: expected %h, got %h",
                                               want_hash, hash_value));
                end
                stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            end
        end
    end

    initial
    begin
        int len;
        int r;
        logic [WORD_W-1:0] klo;
        logic [WORD_W-1:0] khi;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = '0;
        byte_present = 1'b0;
        last         = 1'b0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_KEY_LOW;
        cfg_data     = '0;
        key_lo_m     = KEY_LOW_RESET;
        key_hi_m     = KEY_HIGH_RESET;
        for (int i = 0; i < 4; i++)
            sip_v[i] = '0;
        part_word    = '0;
        part_bytes   = '0;
        msg_len      = '0;
        msg_open     = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message, idle request, single bytes at both extremes
        push_req(8'hA5, 1'b0, 1'b1, 1'b0);
        push_req(8'h3C, 1'b0, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b1, 1'b0);
        push_req(8'hFF, 1'b1, 1'b1, 1'b1);
        // close an open message without a byte
        push_req(8'h01, 1'b1, 1'b0, 1'b0);
        push_req(8'h80, 1'b1, 1'b0, 1'b0);
        push_req(8'h7F, 1'b1, 1'b0, 1'b0);
        push_req(8'h5A, 1'b0, 1'b1, 1'b0);
        // last on the byte that completes a word
        for (int i = 0; i < 4; i++)
            push_req(8'(8'hF0 + i), 1'b1, i == 3, 1'b0);
        // two words' worth less one, with an idle request inside
        for (int i = 0; i < 7; i++)
        begin
            if (i == 3)
                push_req(8'hC3, 1'b0, 1'b0, 1'b0);
            push_req(8'(i * 37 + 11), 1'b1, i == 6, 1'b0);
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1:
                begin
                    klo = '0;
                    khi = '0;
                end
                2:
                begin
                    klo = '1;
                    khi = '1;
                end
                3:
                begin
                    klo = '0;
                    khi = '1;
                end
                4:
                begin
                    klo = '1;
                    khi = '0;
                end
                default:
                begin
                    klo = $urandom;
                    khi = $urandom;
                end
            endcase
            if (ph != 0)
            begin
                write_key(REG_KEY_LOW, klo);
                write_key(REG_KEY_HIGH, khi);
            end
            gap_max   = (ph == 1 || ph == 3 || ph == 4) ? 0 : 6;
            stall_max = (ph == 1 || ph == 4 || ph == 6) ? 0 : 6;

            if (ph == 2 || ph == 5)
                queue_message($urandom_range(256, 300), 1'b1);
            while (item_count < 240 * (ph + 1))
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = 0;
                else if (r < 70)
                    len = $urandom_range(1, 8);
                else if (r < 95)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 80);
                queue_message(len, $urandom_range(0, 24) == 0);
            end
            // leave a message open across the key change
            if (ph == 3 || ph == 5)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    push_req(8'($urandom), 1'b1, 1'b0, 1'b0);
            end
            settle();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
